>>> sv/ihc_pkg.sv
// Package for the IPv4 header checker: field widths, byte offsets and error codes.
// Used by the channel interfaces and by the top level; depends on nothing else.
`default_nettype none
package ihc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned HDR_BYTES_W = 6;
    localparam int unsigned ERR_W      = 3;

    localparam logic [COUNT_W-1:0] OFS_VER_IHL  = 16'd0;
    localparam logic [COUNT_W-1:0] OFS_LEN_HI   = 16'd2;
    localparam logic [COUNT_W-1:0] OFS_LEN_LO   = 16'd3;
    localparam logic [COUNT_W-1:0] OFS_PROTOCOL = 16'd9;
    localparam logic [COUNT_W-1:0] OFS_CSUM_HI  = 16'd10;
    localparam logic [COUNT_W-1:0] OFS_CSUM_LO  = 16'd11;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hffff;

    localparam logic [3:0]        IPV4_VERSION     = 4'd4;
    localparam logic [BYTE_W-1:0] DEFAULT_PROTOCOL = 8'd1;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK          = 3'd0,
        ERR_VERSION     = 3'd1,
        ERR_HDR_BEYOND  = 3'd2,
        ERR_LEN_SHORT   = 3'd3,
        ERR_PROTOCOL    = 3'd4
    } t_err;

endpackage
`default_nettype wire

>>> sv/ihc_in_if.sv
// Input channel of the IPv4 header checker: one packet byte per item.
// Depends on ihc_pkg for field widths.
`default_nettype none
interface ihc_in_if;
    import ihc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_byte;
    logic              last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> sv/ihc_out_if.sv
// Result channel of the IPv4 header checker: one verdict item per packet.
// Depends on ihc_pkg for field widths.
`default_nettype none
interface ihc_out_if;
    import ihc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   header_valid;
    logic [HDR_BYTES_W-1:0] header_bytes;
    logic [ERR_W-1:0]       error_code;
    logic                   checksum_ok;
    logic [WORD_W-1:0]      computed_checksum;

    modport source (
        output valid, output header_valid, output header_bytes, output error_code,
        output checksum_ok, output computed_checksum, input ready
    );
    modport sink (
        input valid, input header_valid, input header_bytes, input error_code,
        input checksum_ok, input computed_checksum, output ready
    );
endinterface
`default_nettype wire

>>> sv/ihc_cfg_if.sv
// Configuration write channel of the IPv4 header checker: the accepted protocol number.
// Depends on ihc_pkg for the field width.
`default_nettype none
interface ihc_cfg_if;
    import ihc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] accepted_protocol;

    modport source (output valid, output accepted_protocol, input ready);
    modport sink (input valid, input accepted_protocol, output ready);
endinterface
`default_nettype wire

>>> sv/ipv4_header_checker.sv
// IPv4 header checker: takes packet bytes one per item and gives one verdict per packet.
// The block accepts one byte in every clock cycle; each byte is registered, then passes one
// 16-bit end-around-carry add and the field captures before the state registers, and the
// verdict is written to the result register when the last byte leaves the input register.
// A waiting verdict stalls input only when the next last byte reaches the input register.
// Depends on ihc_pkg and the interfaces ihc_in_if, ihc_out_if and ihc_cfg_if.
`default_nettype none
module ipv4_header_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ihc_in_if.sink     i_in,
    ihc_cfg_if.sink    i_cfg,
    ihc_out_if.source  o_out
);
    import ihc_pkg::*;

    logic [BYTE_W-1:0]      r_accepted_protocol;

    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    logic                   r_in_last;

    logic [COUNT_W-1:0]     r_byte_count, n_byte_count;
    logic [WORD_W-1:0]      r_sum, n_sum;
    logic [BYTE_W-1:0]      r_hold, n_hold;
    logic [BYTE_W-1:0]      r_version_ihl, n_version_ihl;
    logic [WORD_W-1:0]      r_total_length, n_total_length;
    logic [BYTE_W-1:0]      r_protocol, n_protocol;
    logic [WORD_W-1:0]      r_stored_csum, n_stored_csum;

    logic                   r_out_valid;
    logic                   r_out_header_valid;
    logic [HDR_BYTES_W-1:0] r_out_header_bytes;
    t_err                   r_out_error;
    logic                   r_out_csum_ok;
    logic [WORD_W-1:0]      r_out_csum;

    logic                   out_free;
    logic                   advance;
    logic                   step;
    logic                   step_last;
    logic [HDR_BYTES_W-1:0] hdr_len;
    logic                   in_hdr;
    logic [BYTE_W-1:0]      masked_byte;
    logic                   do_add;
    logic [WORD_W-1:0]      add_word;
    logic [WORD_W:0]        raw_sum;
    logic [WORD_W-1:0]      folded_sum;
    logic [WORD_W-1:0]      csum;
    t_err                   err;

    assign out_free  = !r_out_valid || o_out.ready;
    assign advance   = !r_in_valid || !r_in_last || out_free;
    assign step      = r_in_valid && advance;
    assign step_last = step && r_in_last;

    assign i_in.ready  = advance;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_version_ihl  = (r_byte_count == OFS_VER_IHL) ? r_in_byte : r_version_ihl;
        n_total_length = r_total_length;
        n_stored_csum  = r_stored_csum;
        n_protocol     = (r_byte_count == OFS_PROTOCOL) ? r_in_byte : r_protocol;
        if (r_byte_count == OFS_LEN_HI) begin
            n_total_length[15:8] = r_in_byte;
        end
        if (r_byte_count == OFS_LEN_LO) begin
            n_total_length[7:0] = r_in_byte;
        end
        if (r_byte_count == OFS_CSUM_HI) begin
            n_stored_csum[15:8] = r_in_byte;
        end
        if (r_byte_count == OFS_CSUM_LO) begin
            n_stored_csum[7:0] = r_in_byte;
        end

        hdr_len     = {n_version_ihl[3:0], 2'b00};
        in_hdr      = r_byte_count < {{(COUNT_W-HDR_BYTES_W){1'b0}}, hdr_len};
        masked_byte = (r_byte_count == OFS_CSUM_HI || r_byte_count == OFS_CSUM_LO)
                      ? '0 : r_in_byte;

        n_hold   = (in_hdr && !r_byte_count[0]) ? masked_byte : r_hold;
        do_add   = in_hdr && (r_byte_count[0] || r_in_last);
        add_word = r_byte_count[0] ? {r_hold, masked_byte} : {masked_byte, {BYTE_W{1'b0}}};
        raw_sum  = {1'b0, r_sum} + {1'b0, add_word};
        folded_sum = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};
        n_sum    = do_add ? folded_sum : r_sum;

        n_byte_count = (r_byte_count != COUNT_MAX) ? r_byte_count + 16'd1 : r_byte_count;

        csum = ~n_sum;
        if (n_version_ihl[7:4] != IPV4_VERSION) begin
            err = ERR_VERSION;
        end else if ({{(COUNT_W-HDR_BYTES_W){1'b0}}, hdr_len} > n_byte_count) begin
            err = ERR_HDR_BEYOND;
        end else if (n_total_length < n_byte_count) begin
            err = ERR_LEN_SHORT;
        end else if (n_protocol != r_accepted_protocol) begin
            err = ERR_PROTOCOL;
        end else begin
            err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_protocol <= DEFAULT_PROTOCOL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_accepted_protocol <= i_cfg.accepted_protocol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in.valid;
        end
        if (advance && i_in.valid) begin
            r_in_byte <= i_in.packet_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || step_last) begin
            r_byte_count   <= '0;
            r_sum          <= '0;
            r_hold         <= '0;
            r_version_ihl  <= '0;
            r_total_length <= '0;
            r_protocol     <= '0;
            r_stored_csum  <= '0;
        end else if (step) begin
            r_byte_count   <= n_byte_count;
            r_sum          <= n_sum;
            r_hold         <= n_hold;
            r_version_ihl  <= n_version_ihl;
            r_total_length <= n_total_length;
            r_protocol     <= n_protocol;
            r_stored_csum  <= n_stored_csum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (step_last) begin
            r_out_header_valid <= (err == ERR_OK);
            r_out_header_bytes <= hdr_len;
            r_out_error        <= err;
            r_out_csum_ok      <= (csum == n_stored_csum);
            r_out_csum         <= csum;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.header_valid      = r_out_header_valid;
    assign o_out.header_bytes      = r_out_header_bytes;
    assign o_out.error_code        = r_out_error;
    assign o_out.checksum_ok       = r_out_csum_ok;
    assign o_out.computed_checksum = r_out_csum;

`ifndef SYNTHESIS
    a_valid_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_header_valid == (r_out_error == ERR_OK)))
        else $error("header_valid disagrees with error_code");

    a_hdr_bytes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_header_bytes[1:0] == 2'b00))
        else $error("header_bytes is not a multiple of four");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && !out_free) |=> (r_in_valid && r_in_last))
        else $error("a stalled last byte was dropped");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_last |=> (r_byte_count == '0 && r_sum == '0 && r_out_valid))
        else $error("packet state not cleared after verdict");
`endif

endmodule
`default_nettype wire
